// ----- hdl/nrtp_pkg.sv -----
`default_nettype none
package nrtp_pkg;

    localparam int TIME_BITS   = 48;
    localparam int REGIONS     = 64;
    localparam int REGION_BITS = $clog2(REGIONS);
    localparam int STACK_DEPTH = 64;
    localparam int STACK_BITS  = $clog2(STACK_DEPTH);
    localparam int LEVEL_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_START = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_END   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_PUSH  = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_POP   = 3'd5;

    // status codes
    localparam logic [STATUS_BITS-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STS_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STS_EMPTY    = 2'd2;
    localparam logic [STATUS_BITS-1:0] STS_MISMATCH = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [CMD_BITS-1:0]    cmd;
        logic [REGION_BITS-1:0] region;
        logic [TIME_BITS-1:0]   timestamp;
    } t_cmd_item;

    typedef struct packed {
        logic [TIME_BITS-1:0]   region_total;
        logic [STATUS_BITS-1:0] status;
    } t_result_item;

    // read addresses for the region store
    typedef struct packed {
        logic [REGION_BITS-1:0] addr_a;
        logic [REGION_BITS-1:0] addr_b;
    } t_rgn_rd;

    // registered read data from the region store
    typedef struct packed {
        logic [TIME_BITS-1:0] total_a;
        logic [TIME_BITS-1:0] start_a;
        logic [TIME_BITS-1:0] total_b;
    } t_rgn_data;

    // write requests to the region store
    typedef struct packed {
        logic                   total_we;
        logic [REGION_BITS-1:0] total_addr;
        logic [TIME_BITS-1:0]   total_data;
        logic                   start_we;
        logic [REGION_BITS-1:0] start_addr;
        logic [TIME_BITS-1:0]   start_data;
    } t_rgn_wr;

    // stack update request
    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic [REGION_BITS-1:0] region;
    } t_stk_upd;

    // stack status
    typedef struct packed {
        logic [LEVEL_BITS-1:0]  level;
        logic [REGION_BITS-1:0] top;
        logic [REGION_BITS-1:0] below;
    } t_stk_stat;

endpackage
`default_nettype wire

// ----- hdl/nrtp_region_store.sv -----
`default_nettype none
module nrtp_region_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nrtp_pkg::t_rgn_rd  i_rd,
    input  wire nrtp_pkg::t_rgn_wr  i_wr,
    output nrtp_pkg::t_rgn_data     o_data
);
    import nrtp_pkg::*;

    logic [TIME_BITS-1:0] m_total [REGIONS];
    logic [TIME_BITS-1:0] m_start [REGIONS];
    logic [REGIONS-1:0]   r_total_vld;
    logic [REGIONS-1:0]   r_start_vld;

    logic [TIME_BITS-1:0] r_total_a;
    logic [TIME_BITS-1:0] r_start_a;
    logic [TIME_BITS-1:0] r_total_b;
    logic                 r_total_a_vld;
    logic                 r_start_a_vld;
    logic                 r_total_b_vld;

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.total_we) begin
            m_total[i_wr.total_addr] <= i_wr.total_data;
        end
        if (i_wr.start_we) begin
            m_start[i_wr.start_addr] <= i_wr.start_data;
        end
        r_total_a <= m_total[i_rd.addr_a];
        r_start_a <= m_start[i_rd.addr_a];
        r_total_b <= m_total[i_rd.addr_b];
    end

    // per-entry valid bits stand in for clearing at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_vld   <= '0;
            r_start_vld   <= '0;
            r_total_a_vld <= 1'b0;
            r_start_a_vld <= 1'b0;
            r_total_b_vld <= 1'b0;
        end else begin
            if (i_wr.total_we) begin
                r_total_vld[i_wr.total_addr] <= 1'b1;
            end
            if (i_wr.start_we) begin
                r_start_vld[i_wr.start_addr] <= 1'b1;
            end
            r_total_a_vld <= r_total_vld[i_rd.addr_a];
            r_start_a_vld <= r_start_vld[i_rd.addr_a];
            r_total_b_vld <= r_total_vld[i_rd.addr_b];
        end
    end

    // entries never written read as zero
    always_comb begin
        o_data.total_a = r_total_a_vld ? r_total_a : '0;
        o_data.start_a = r_start_a_vld ? r_start_a : '0;
        o_data.total_b = r_total_b_vld ? r_total_b : '0;
    end

endmodule
`default_nettype wire

// ----- hdl/nrtp_nest_stack.sv -----
`default_nettype none
module nrtp_nest_stack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nrtp_pkg::t_stk_upd i_upd,
    output nrtp_pkg::t_stk_stat     o_stat
);
    import nrtp_pkg::*;

    // entries beneath the top; the top itself sits in a register
    logic [REGION_BITS-1:0] m_stack [STACK_DEPTH];
    logic [LEVEL_BITS-1:0]  r_level;
    logic [LEVEL_BITS-1:0]  n_level;
    logic [REGION_BITS-1:0] r_top;
    logic [REGION_BITS-1:0] n_top;
    logic [REGION_BITS-1:0] r_below;
    logic [LEVEL_BITS-1:0]  w_wr_idx;
    logic [LEVEL_BITS-1:0]  w_rd_idx;

    assign w_wr_idx = r_level - LEVEL_BITS'(1);
    assign w_rd_idx = r_level - LEVEL_BITS'(2);

    // old top goes to memory on push, entry beneath is read every cycle
    always_ff @(posedge i_clk) begin
        if (i_upd.push && (r_level != '0)) begin
            m_stack[w_wr_idx[STACK_BITS-1:0]] <= r_top;
        end
        r_below <= m_stack[w_rd_idx[STACK_BITS-1:0]];
    end

    // level and top update
    always_comb begin
        n_level = r_level;
        n_top   = r_top;
        if (i_upd.push) begin
            n_level = r_level + LEVEL_BITS'(1);
            n_top   = i_upd.region;
        end else if (i_upd.pop) begin
            n_level = r_level - LEVEL_BITS'(1);
            n_top   = r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_top   <= '0;
        end else begin
            r_level <= n_level;
            r_top   <= n_top;
        end
    end

    assign o_stat.level = r_level;
    assign o_stat.top   = r_top;
    assign o_stat.below = r_below;

endmodule
`default_nettype wire

// ----- hdl/nrtp_ctrl.sv -----
`default_nettype none
module nrtp_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire nrtp_pkg::t_cmd_item    i_item,
    input  wire nrtp_pkg::t_rgn_data    i_rgn,
    input  wire nrtp_pkg::t_stk_stat    i_stk,
    output nrtp_pkg::t_rgn_rd           o_rgn_rd,
    output nrtp_pkg::t_rgn_wr           o_rgn_wr,
    output nrtp_pkg::t_stk_upd          o_stk_upd,
    output logic                        o_busy,
    output logic                        o_valid,
    output nrtp_pkg::t_result_item      o_result
);
    import nrtp_pkg::*;

    t_state       r_state;
    t_state       n_state;
    t_cmd_item    r_item;
    logic         w_accept;
    logic         w_exec;
    logic         r_valid;
    t_result_item r_result;
    t_result_item n_result;

    logic [TIME_BITS-1:0] w_delta;
    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_charged;
    logic                 w_full;
    logic                 w_empty;

    assign w_exec   = (r_state == ST_EXEC);
    assign w_accept = i_start && !w_exec;

    // read addresses: push charges the stack top, all others the named region
    always_comb begin
        o_rgn_rd.addr_a = (i_item.cmd == CMD_PUSH) ? i_stk.top : i_item.region;
        o_rgn_rd.addr_b = i_item.region;
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    // elapsed time wraps, total saturates
    always_comb begin
        w_delta   = r_item.timestamp - i_rgn.start_a;
        w_sum     = {1'b0, i_rgn.total_a} + {1'b0, w_delta};
        w_charged = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];
        w_full    = (i_stk.level == LEVEL_BITS'(STACK_DEPTH));
        w_empty   = (i_stk.level == '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // execute: memory writes, stack update and result
    always_comb begin
        o_rgn_wr             = '0;
        o_rgn_wr.total_addr  = r_item.region;
        o_rgn_wr.start_addr  = r_item.region;
        o_rgn_wr.start_data  = r_item.timestamp;
        o_stk_upd            = '0;
        o_stk_upd.region     = r_item.region;
        n_result.region_total = i_rgn.total_b;
        n_result.status       = STS_OK;
        if (w_exec) begin
            case (r_item.cmd)
                CMD_CLEAR: begin
                    o_rgn_wr.total_we     = 1'b1;
                    o_rgn_wr.total_data   = '0;
                    n_result.region_total = '0;
                end
                CMD_START: begin
                    o_rgn_wr.start_we = 1'b1;
                end
                CMD_END: begin
                    o_rgn_wr.total_we     = 1'b1;
                    o_rgn_wr.total_data   = w_charged;
                    n_result.region_total = w_charged;
                end
                CMD_PUSH: begin
                    if (w_full) begin
                        n_result.status = STS_FULL;
                    end else begin
                        o_stk_upd.push    = 1'b1;
                        o_rgn_wr.start_we = 1'b1;
                        if (!w_empty) begin
                            o_rgn_wr.total_we   = 1'b1;
                            o_rgn_wr.total_addr = i_stk.top;
                            o_rgn_wr.total_data = w_charged;
                            if (i_stk.top == r_item.region) begin
                                n_result.region_total = w_charged;
                            end
                        end
                    end
                end
                CMD_POP: begin
                    if (w_empty) begin
                        n_result.status = STS_EMPTY;
                    end else begin
                        if (i_stk.top != r_item.region) begin
                            n_result.status = STS_MISMATCH;
                        end
                        o_stk_upd.pop         = 1'b1;
                        o_rgn_wr.total_we     = 1'b1;
                        o_rgn_wr.total_data   = w_charged;
                        n_result.region_total = w_charged;
                        // restart the region beneath
                        if (i_stk.level != LEVEL_BITS'(1)) begin
                            o_rgn_wr.start_we   = 1'b1;
                            o_rgn_wr.start_addr = i_stk.below;
                        end
                    end
                end
                default: begin
                    n_result.status = STS_OK;
                end
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_result <= n_result;
        end
    end

    // outputs
    always_comb begin
        o_busy   = w_exec;
        o_valid  = r_valid;
        o_result = r_result;
    end

endmodule
`default_nettype wire

// ----- hdl/nested_region_time_profiler.sv -----
`default_nettype none
// nested region time profiler
// keeps a tick total per region and a nesting stack of regions
// command channel: drive i_item (cmd, region, timestamp) with start high;
// the transaction is taken at a rising edge where start is high and busy is low
// busy is high for one cycle after each transaction, so a new command is
// not taken while the last one executes; the region and start memories are
// read in the accept cycle and written back in the execute cycle that follows
// result channel: o_valid pulses for one cycle with o_result (region_total,
// status) from registers loaded in the execute state; one result per command
// the receiver cannot stall, so every result must be taken in its cycle
// reset (i_rst_n low at a rising edge) empties the stack and makes every
// region total and start read as zero at once, with no clearing pass
// a full push or an empty pop is flagged and ignored; a pop of a region
// other than the top is flagged and still carried out
module nested_region_time_profiler (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire nrtp_pkg::t_cmd_item    i_item,
    output logic                        busy,
    output logic                        o_valid,
    output nrtp_pkg::t_result_item      o_result
);
    import nrtp_pkg::*;

    t_rgn_rd   w_rgn_rd;
    t_rgn_wr   w_rgn_wr;
    t_rgn_data w_rgn_data;
    t_stk_upd  w_stk_upd;
    t_stk_stat w_stk_stat;

    // command sequencer and charge arithmetic
    nrtp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_rgn     (w_rgn_data),
        .i_stk     (w_stk_stat),
        .o_rgn_rd  (w_rgn_rd),
        .o_rgn_wr  (w_rgn_wr),
        .o_stk_upd (w_stk_upd),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    // region totals and start times
    nrtp_region_store u_region_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_rgn_rd),
        .i_wr    (w_rgn_wr),
        .o_data  (w_rgn_data)
    );

    // nesting stack
    nrtp_nest_stack u_nest_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_stk_upd),
        .o_stat  (w_stk_stat)
    );

endmodule
`default_nettype wire
